[hw/rtl/tdf_pkg.sv]
// package for the trial division factorizer
// holds field widths, run limit and the shared result command struct
// no dependencies
package tdf_pkg;

    localparam int WIDTH       = 32;
    localparam int PRIME_W     = 32;
    localparam int EXP_W       = 5;
    localparam int MAX_RESULTS = 9;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int DIV_CNT_W   = $clog2(WIDTH + 1);

    typedef logic [WIDTH-1:0]   t_word;
    typedef logic [PRIME_W-1:0] t_prime;
    typedef logic [EXP_W-1:0]   t_exp;
    typedef logic [CNT_W-1:0]   t_cnt;

    // command from the sequencer to the result buffer
    typedef struct packed {
        logic   push;
        logic   finish;
        t_prime prime;
        t_exp   exponent;
    } t_rb_cmd;

endpackage

[hw/rtl/trial_division_factorizer.sv]
// top level of the trial division factorizer: sequencer, divider and result buffer
// depends on tdf_pkg, tdf_divider and tdf_result_buf
//
// usage
//   input channel i_valid/o_ready carries i_value; output channel o_valid/i_ready
//   carries o_prime, o_exponent and o_last, one transfer per distinct prime factor,
//   ascending, with o_last set on the final one. inputs 0 and 1 give no transfers.
//   one value is factored at a time; o_ready is high only while the sequencer idles.
//   factors of two are stripped at one per cycle. each odd trial divisor costs one
//   pass of the bit-serial divider, and the divisor is retried after every exact
//   division. a value with largest prime near 2^32 tries about 32768 divisors;
//   small or smooth values try far fewer, as the search ends once the divisor
//   exceeds the quotient.
//   a factor is held back until the next one or the end of the run is found, so the
//   first transfer appears only once the second factor (or the end) is known.
//   if the receiver stalls, the sequencer waits at the next factor it must hand on;
//   no result is dropped. reset empties the output register and returns to idle.
module trial_division_factorizer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  tdf_pkg::t_word        i_value,
    output logic                  o_valid,
    input  logic                  i_ready,
    output tdf_pkg::t_prime       o_prime,
    output tdf_pkg::t_exp         o_exponent,
    output logic                  o_last
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_TWO  = 7'b0000010,
        S_GO   = 7'b0000100,
        S_WAIT = 7'b0001000,
        S_DEC  = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_END  = 7'b1000000
    } t_state;

    t_state           r_state, n_state;
    tdf_pkg::t_word   r_rem, n_rem;
    tdf_pkg::t_word   r_d, n_d;
    tdf_pkg::t_exp    r_e, n_e;
    tdf_pkg::t_cnt    r_cnt, n_cnt;

    tdf_pkg::t_rb_cmd cmd;
    logic             cmd_ready;
    logic             div_start;
    logic             div_busy;
    tdf_pkg::t_word   quo;
    tdf_pkg::t_word   rmd;
    logic             room;

    assign room = r_cnt < tdf_pkg::t_cnt'(tdf_pkg::MAX_RESULTS);

    always_comb begin
        n_state   = r_state;
        n_rem     = r_rem;
        n_d       = r_d;
        n_e       = r_e;
        n_cnt     = r_cnt;
        cmd       = '0;
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_rem = i_value;
                    n_e   = '0;
                    n_cnt = '0;
                    if (i_value > tdf_pkg::t_word'(1)) begin
                        n_state = S_TWO;
                    end
                end
            end
            S_TWO: begin
                if (!r_rem[0]) begin
                    n_rem = r_rem >> 1;
                    n_e   = r_e + 1'b1;
                end else if (r_e != '0 && room) begin
                    cmd.push     = 1'b1;
                    cmd.prime    = tdf_pkg::t_prime'(2);
                    cmd.exponent = r_e;
                    if (cmd_ready) begin
                        n_cnt   = r_cnt + 1'b1;
                        n_d     = tdf_pkg::t_word'(3);
                        n_e     = '0;
                        n_state = S_GO;
                    end
                end else begin
                    n_d     = tdf_pkg::t_word'(3);
                    n_e     = '0;
                    n_state = S_GO;
                end
            end
            S_GO: begin
                div_start = 1'b1;
                n_state   = S_WAIT;
            end
            S_WAIT: begin
                if (!div_busy) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (r_e == '0 && r_d > quo) begin
                    n_state = S_FIN;
                end else if (rmd == '0) begin
                    n_rem   = quo;
                    n_e     = r_e + 1'b1;
                    n_state = S_GO;
                end else if (r_e != '0 && room) begin
                    cmd.push     = 1'b1;
                    cmd.prime    = tdf_pkg::t_prime'(r_d);
                    cmd.exponent = r_e;
                    if (cmd_ready) begin
                        n_cnt   = r_cnt + 1'b1;
                        n_d     = r_d + tdf_pkg::t_word'(2);
                        n_e     = '0;
                        n_state = S_GO;
                    end
                end else begin
                    n_d     = r_d + tdf_pkg::t_word'(2);
                    n_e     = '0;
                    n_state = S_GO;
                end
            end
            S_FIN: begin
                if (r_rem > tdf_pkg::t_word'(2) && room) begin
                    cmd.push     = 1'b1;
                    cmd.prime    = tdf_pkg::t_prime'(r_rem);
                    cmd.exponent = tdf_pkg::t_exp'(1);
                    if (cmd_ready) begin
                        n_cnt   = r_cnt + 1'b1;
                        n_state = S_END;
                    end
                end else begin
                    n_state = S_END;
                end
            end
            S_END: begin
                cmd.finish = 1'b1;
                if (cmd_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_e     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_e     <= n_e;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_d   <= n_d;
    end

    assign o_ready = r_state == S_IDLE;

    tdf_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (r_rem),
        .i_divisor   (r_d),
        .o_busy      (div_busy),
        .o_quotient  (quo),
        .o_remainder (rmd)
    );

    tdf_result_buf u_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_prime     (o_prime),
        .o_exponent  (o_exponent),
        .o_last      (o_last)
    );

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !div_busy)
        else $error("divider busy while sequencer idle");

    a_exp_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_exponent != '0 && o_prime > tdf_pkg::t_prime'(1))
        else $error("result with zero exponent or prime below two");

    a_run_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= tdf_pkg::t_cnt'(tdf_pkg::MAX_RESULTS))
        else $error("run longer than the result limit");

    a_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

endmodule

[hw/rtl/tdf_divider.sv]
// bit-serial restoring divider, one quotient bit per cycle
// busy from a start pulse until all WIDTH quotient bits are formed; depends on tdf_pkg
module tdf_divider (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  tdf_pkg::t_word i_dividend,
    input  tdf_pkg::t_word i_divisor,
    output logic           o_busy,
    output tdf_pkg::t_word o_quotient,
    output tdf_pkg::t_word o_remainder
);

    localparam int W = tdf_pkg::WIDTH;

    logic [tdf_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    tdf_pkg::t_word                r_quo;
    tdf_pkg::t_word                r_rem;
    tdf_pkg::t_word                r_dsr;

    logic [W:0]     trial;
    logic [W:0]     diff;
    logic           ge;
    tdf_pkg::t_word n_rem;

    // partial remainder stays below the divisor, so the borrow bit gives the compare
    always_comb begin
        trial = {r_rem, r_quo[W-1]};
        diff  = trial - {1'b0, r_dsr};
        ge    = !diff[W];
        n_rem = ge ? diff[W-1:0] : trial[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= tdf_pkg::DIV_CNT_W'(W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == tdf_pkg::DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

[hw/rtl/tdf_result_buf.sv]
// holds one pending factor until the next one or the end of the run is known
// then moves it to the output register with its last flag; depends on tdf_pkg
module tdf_result_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tdf_pkg::t_rb_cmd  i_cmd,
    output logic              o_cmd_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output tdf_pkg::t_prime   o_prime,
    output tdf_pkg::t_exp     o_exponent,
    output logic              o_last
);

    logic            r_pend_valid;
    tdf_pkg::t_prime r_pend_prime;
    tdf_pkg::t_exp   r_pend_exp;
    logic            r_out_valid;
    tdf_pkg::t_prime r_out_prime;
    tdf_pkg::t_exp   r_out_exp;
    logic            r_out_last;

    logic out_free;
    logic move;

    assign out_free    = !r_out_valid || i_ready;
    assign o_cmd_ready = out_free;
    assign move        = (i_cmd.push || i_cmd.finish) && out_free && r_pend_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end
            if (out_free && i_cmd.push) begin
                r_pend_valid <= 1'b1;
            end else if (out_free && i_cmd.finish) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_prime <= r_pend_prime;
            r_out_exp   <= r_pend_exp;
            r_out_last  <= i_cmd.finish && !i_cmd.push;
        end
        if (out_free && i_cmd.push) begin
            r_pend_prime <= i_cmd.prime;
            r_pend_exp   <= i_cmd.exponent;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_prime    = r_out_prime;
    assign o_exponent = r_out_exp;
    assign o_last     = r_out_last;

endmodule

[test/trial_division_factorizer_tb.sv]
// testbench for trial_division_factorizer: directed and random values, each factored by
// an in-bench trial division predictor, results checked in order with random idling
// depends on tdf_pkg and the trial_division_factorizer rtl
module trial_division_factorizer_tb;

    typedef struct {
        tdf_pkg::t_prime prime;
        tdf_pkg::t_exp   exponent;
        logic            last;
    } t_factor;

    typedef struct {
        tdf_pkg::t_word value;
        bit             drain;
    } t_offer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_value = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_prime;
    logic [4:0]  o_exponent;
    logic        o_last;

    t_offer  value_q[$];
    t_factor factor_q[$];
    t_factor want;

    int errors = 0;
    int values_accepted = 0;
    int empty_runs = 0;
    int transfers = 0;
    int longest_run = 0;
    logic calm;

    int unsigned small_primes [0:24] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41,
                                         43, 47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97};

    trial_division_factorizer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_prime    (o_prime),
        .o_exponent (o_exponent),
        .o_last     (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // no idling on either side for a stretch of twenty values
    assign calm = (values_accepted >= 40) && (values_accepted < 60);

    // trial division of one value, queueing its run of prime factors
    function automatic void push_factorization(input tdf_pkg::t_word value);
        longint unsigned rem;
        longint unsigned d;
        int              e;
        t_factor         run[$];
        t_factor         f;
        rem = value;
        if (rem < 2) begin
            empty_runs++;
            return;
        end
        e = 0;
        while (rem[0] == 1'b0) begin
            rem = rem >> 1;
            e++;
        end
        if (e != 0) begin
            f.prime = tdf_pkg::t_prime'(2);
            f.exponent = tdf_pkg::t_exp'(e);
            f.last = 1'b0;
            run.insert(run.size(), f);
        end
        for (d = 3; d * d <= rem; d += 2) begin
            e = 0;
            while (rem % d == 0) begin
                rem = rem / d;
                e++;
            end
            if (e != 0 && run.size() < tdf_pkg::MAX_RESULTS) begin
                f.prime = tdf_pkg::t_prime'(d);
                f.exponent = tdf_pkg::t_exp'(e);
                f.last = 1'b0;
                run.insert(run.size(), f);
            end
        end
        if (rem > 2 && run.size() < tdf_pkg::MAX_RESULTS) begin
            f.prime = tdf_pkg::t_prime'(rem);
            f.exponent = tdf_pkg::t_exp'(1);
            f.last = 1'b0;
            run.insert(run.size(), f);
        end
        run[run.size() - 1].last = 1'b1;
        if (run.size() > longest_run)
            longest_run = run.size();
        foreach (run[k])
            factor_q.insert(factor_q.size(), run[k]);
    endfunction

    // mostly smooth or small values so that trial division stays short
    function automatic tdf_pkg::t_word random_value();
        longint unsigned v;
        longint unsigned p;
        int              pick;
        int              n;
        v = 1;
        pick = $urandom_range(0, 99);
        if (pick < 75 && pick >= 45) begin
            v = $urandom_range(0, 65535);
        end else if (pick >= 90) begin
            v = $urandom_range(0, 1 << 20);
        end else begin
            n = (pick < 45) ? $urandom_range(1, 14) : $urandom_range(1, 6);
            repeat (n) begin
                p = small_primes[$urandom_range(0, 24)];
                if ($urandom_range(0, 3) == 0)
                    p = small_primes[$urandom_range(0, 2)];
                if (v * p <= 64'hFFFF_FFFF)
                    v = v * p;
            end
            if (pick >= 75) begin
                p = $urandom_range(2, 65535);
                if (v * p <= 64'hFFFF_FFFF)
                    v = v * p;
            end
        end
        return tdf_pkg::t_word'(v);
    endfunction

    task automatic offer(input tdf_pkg::t_word value, input bit drain);
        t_offer o;
        o.value = value;
        o.drain = drain;
        value_q.insert(value_q.size(), o);
    endtask

    task automatic note_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("mismatch: %s", msg);
    endtask

    // input side: hold valid and payload until the transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                push_factorization(i_value);
                values_accepted++;
            end
            if (!i_valid || o_ready) begin
                if (value_q.size() != 0 && (calm || $urandom_range(0, 99) >= 30)
                        && !(value_q[0].drain && factor_q.size() != 0)) begin
                    i_value <= value_q[0].value;
                    i_valid <= 1'b1;
                    void'(value_q.pop_front());
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // output side: compare every transfer with the oldest expected factor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                transfers++;
                if (factor_q.size() == 0) begin
                    note_error($sformatf("unexpected transfer prime %0d exponent %0d last %0b",
                                         o_prime, o_exponent, o_last));
                end else begin
                    want = factor_q.pop_front();
                    if (o_prime !== want.prime || o_exponent !== want.exponent
                            || o_last !== want.last)
                        note_error($sformatf(
                            "expected prime %0d exponent %0d last %0b, got %0d %0d %0b",
                            want.prime, want.exponent, want.last,
                            o_prime, o_exponent, o_last));
                end
            end
            i_ready <= calm || ($urandom_range(0, 99) >= 30);
        end
    end

    initial begin
        offer(32'd0, 1'b0);
        offer(32'd1, 1'b0);
        offer(32'd2, 1'b0);
        offer(32'd3, 1'b0);
        offer(32'd4, 1'b0);
        offer(32'd6, 1'b0);
        offer(32'd9, 1'b0);
        offer(32'd25, 1'b0);
        offer(32'd49, 1'b0);
        offer(32'd63001, 1'b0);
        offer(32'd65521, 1'b0);
        offer(32'h8000_0000, 1'b0);
        offer(32'hFFFF_FFFF, 1'b0);
        offer(32'h5555_5555, 1'b0);
        offer(32'hAAAA_AAAA, 1'b0);
        offer(32'd223092870, 1'b0);
        offer(32'd3486784401, 1'b0);
        offer(32'd4294967291, 1'b1);
        offer(32'd16777213, 1'b0);
        offer(32'd1, 1'b1);
        for (int k = 0; k < 90; k++)
            offer(random_value(), (k % 30) == 15);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (value_q.size() != 0 || i_valid || factor_q.size() != 0)
            @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("factored %0d values (%0d with no factors), %0d factor transfers checked",
                 values_accepted, empty_runs, transfers);
        $display("longest run %0d factors, %0d mismatches", longest_run, errors);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #300_000_000;
        $display("timeout with %0d values still queued", value_q.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[trial_division_factorizer.f]
hw/rtl/tdf_pkg.sv
hw/rtl/tdf_divider.sv
hw/rtl/tdf_result_buf.sv
hw/rtl/trial_division_factorizer.sv
test/trial_division_factorizer_tb.sv
